// File: design/lnt_pkg.sv
// ---------------------------------------------------------------------------
// lnt_pkg: shared constants for the lattice NTT engine
// Modulus, Montgomery inverse, inverse scaling factor and command codes.
// ---------------------------------------------------------------------------
package lnt_pkg;
  localparam int COEFF_COUNT = 256;
  localparam int IDX_W       = $clog2(COEFF_COUNT);
  localparam logic signed [63:0] MOD_Q    = 64'sd8380417;
  localparam logic [31:0]        MOD_QINV = 32'd58728449;
  localparam logic [31:0]        INV_SCALE = 32'd41978;

  localparam logic [1:0] CMD_WR_TW   = 2'd0;
  localparam logic [1:0] CMD_WR_COEF = 2'd1;
  localparam logic [1:0] CMD_RUN     = 2'd2;
  localparam logic [1:0] CMD_RD_COEF = 2'd3;
endpackage

// File: design/lnt_mont.sv
// ---------------------------------------------------------------------------
// lnt_mont: pipelined signed Montgomery multiply
// r = (a*b - t*q) / 2^32 with t = low32(a*b) * qinv; registers p1, t, tq, r.
// ---------------------------------------------------------------------------
module lnt_mont (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] r
);
  import lnt_pkg::*;

  logic [3:0]         vld;
  logic signed [63:0] p1, p2, p3, tq;
  logic [31:0]        t;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    p1 <= $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    t  <= p1[31:0] * MOD_QINV;
    p2 <= p1;
    tq <= $signed({{32{t[31]}}, t}) * MOD_Q;
    p3 <= p2;
  end

  logic signed [63:0] diff;
  assign diff = p3 - tq;

  always_ff @(posedge clk) begin
    r <= diff[63:32];
  end

  assign done = vld[3];
endmodule

// File: design/lattice_ntt_forward_inverse_top.sv
// ---------------------------------------------------------------------------
// lattice_ntt_forward_inverse_top: NTT / inverse NTT engine, q = 8380417
// Command input channel, coefficient read-back output channel, direction reg.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall, cmd/index/value): write twiddle, write
// coefficient, run transform, read coefficient. Writes do not stall the input.
// A read returns one transaction on the output channel (out_valid/out_stall)
// by way of the S_RDOUT state and blocks the input while in it; the output
// register holds it while stalled, and further commands are taken meanwhile,
// but a second read waits until the register is free.
// A run walks 1024 butterflies, one at a time through the coefficient memory
// (one read port, one write port): two reads, the four-stage Montgomery
// pipeline, two writes. The inverse adds a scaling pass over every
// coefficient. The input is stalled for the whole run.
// direction is written through cfg_valid/cfg_ready/cfg_data while idle.
// Reset (rst, synchronous) clears control state and direction; both
// memories hold unknown contents until written.
// ---------------------------------------------------------------------------
module lattice_ntt_forward_inverse_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  index,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_index,
  output logic signed [31:0] out_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import lnt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDOUT = 4'd1;
  localparam logic [3:0] B_LO    = 4'd2;
  localparam logic [3:0] B_HI    = 4'd3;
  localparam logic [3:0] B_MUL   = 4'd4;
  localparam logic [3:0] B_WAIT  = 4'd5;
  localparam logic [3:0] B_WR1   = 4'd6;
  localparam logic [3:0] B_WR2   = 4'd7;
  localparam logic [3:0] C_LO    = 4'd8;
  localparam logic [3:0] C_MUL   = 4'd9;
  localparam logic [3:0] C_WAIT  = 4'd10;
  localparam logic [3:0] C_WR    = 4'd11;

  logic [3:0]       state;
  logic             direction;
  logic [2:0]       lyr;
  logic [6:0]       bf;
  logic [IDX_W-1:0] sj;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      lo, m;

  logic [31:0] coef_mem [COEFF_COUNT];
  logic [31:0] tw_mem   [COEFF_COUNT];
  logic [31:0] coef_q, tw_q;

  logic             c_we;
  logic [IDX_W-1:0] c_waddr, c_raddr;
  logic [31:0]      c_wdata;

  logic in_acc, out_free;
  // direction only changes between runs
  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE) || (cmd == CMD_RD_COEF && out_valid);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // butterfly addressing
  logic [7:0] len8, mask8, b8, j_lo, j_hi, k8;
  logic [6:0] grp;
  logic [8:0] k9;
  logic       fwd;
  assign fwd   = !direction;
  assign len8  = fwd ? (8'd128 >> lyr) : (8'd1 << lyr);
  assign mask8 = len8 - 8'd1;
  assign b8    = {1'b0, bf};
  assign j_lo  = ((b8 & ~mask8) << 1) | (b8 & mask8);
  assign j_hi  = j_lo | len8;
  assign grp   = fwd ? (bf >> (3'd7 - lyr)) : (bf >> lyr);
  assign k9    = fwd ? ((9'd1 << lyr) + {2'b0, grp})
                     : ((9'd256 >> lyr) - 9'd1 - {2'b0, grp});
  assign k8    = k9[7:0];

  // prod keeps hi for the inverse sum; m takes the Montgomery result
  logic [31:0] prod;

  // memories
  always_comb begin
    c_raddr = index;
    unique case (state)
      S_RDOUT: c_raddr = rd_idx;
      B_LO:    c_raddr = j_lo;
      B_HI:    c_raddr = j_hi;
      C_LO:    c_raddr = sj;
      default: c_raddr = index;
    endcase
  end

  always_comb begin
    c_we    = 1'b0;
    c_waddr = index;
    c_wdata = value;
    unique case (state)
      S_IDLE: c_we = in_acc && cmd == CMD_WR_COEF;
      B_WR1: begin
        c_we    = 1'b1;
        c_waddr = j_lo;
        c_wdata = fwd ? lo + m : lo + prod;
      end
      B_WR2: begin
        c_we    = 1'b1;
        c_waddr = j_hi;
        c_wdata = fwd ? lo - m : m;
      end
      C_WR: begin
        c_we    = 1'b1;
        c_waddr = sj;
        c_wdata = m;
      end
      default: c_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) coef_mem[c_waddr] <= c_wdata;
    coef_q <= coef_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc && cmd == CMD_WR_TW) tw_mem[index] <= value;
    tw_q <= tw_mem[k8];
  end

  // Montgomery unit
  logic        mm_start, mm_done;
  logic [31:0] mm_a, mm_b, mm_r, hi_v;
  assign hi_v = coef_q;
  always_comb begin
    mm_start = (state == B_MUL) || (state == C_MUL);
    if (state == C_MUL) begin
      mm_a = INV_SCALE;
      mm_b = coef_q;
    end else begin
      mm_a = fwd ? tw_q : 32'd0 - tw_q;
      mm_b = fwd ? hi_v : lo - hi_v;
    end
  end

  lnt_mont u_mont (
    .clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b),
    .done(mm_done), .r(mm_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      direction <= 1'b0;
      out_valid <= 1'b0;
      lyr       <= '0;
      bf        <= '0;
      sj        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) direction <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc && cmd == CMD_RD_COEF) begin
            state <= S_RDOUT;
          end else if (in_acc && cmd == CMD_RUN) begin
            lyr   <= '0;
            bf    <= '0;
            state <= B_LO;
          end
        end
        S_RDOUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        B_LO:   state <= B_HI;
        B_HI:   state <= B_MUL;
        B_MUL:  state <= B_WAIT;
        B_WAIT: if (mm_done) state <= B_WR1;
        B_WR1:  state <= B_WR2;
        B_WR2: begin
          bf <= bf + 7'd1;
          if (bf == 7'd127) begin
            lyr <= lyr + 3'd1;
            if (lyr == 3'd7) begin
              sj    <= '0;
              state <= direction ? C_LO : S_IDLE;
            end else begin
              state <= B_LO;
            end
          end else begin
            state <= B_LO;
          end
        end
        C_LO:   state <= C_MUL;
        C_MUL:  state <= C_WAIT;
        C_WAIT: if (mm_done) state <= C_WR;
        C_WR: begin
          sj    <= sj + 1'b1;
          state <= (sj == IDX_W'(COEFF_COUNT - 1)) ? S_IDLE : C_LO;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) rd_idx <= index;
    if (state == S_RDOUT && out_free) begin
      out_index <= rd_idx;
      out_value <= coef_q;
    end
    if (state == B_HI) lo <= coef_q;
    if (state == B_MUL) prod <= coef_q;
    if (mm_done) m <= mm_r;
  end

`ifndef NO_ASSERTIONS
  a_mont_lat: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> ##4 mm_done)
    else $error("Montgomery result not on time");
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == B_WAIT || state == C_WAIT))
    else $error("Montgomery result outside wait state");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RDOUT)
    else $error("result raised outside read-out");
`endif
endmodule
